// ===== rtl/ssfh_pkg.sv =====
// shared types and constants for the serial settings frame handler
// no dependencies; used by every module of the block
package ssfh_pkg;

	localparam int unsigned SET_BYTES = 23;
	localparam int unsigned SET_IDX_W = 5;

	typedef logic [7:0] byte_t;

	// configuration register indexes
	localparam logic [1:0] REG_READ_CODE  = 2'd0;
	localparam logic [1:0] REG_WRITE_CODE = 2'd1;
	localparam logic [1:0] REG_ACK_CODE   = 2'd2;

	localparam byte_t READ_CODE_RST  = 8'h01;
	localparam byte_t WRITE_CODE_RST = 8'h02;
	localparam byte_t ACK_CODE_RST   = 8'h06;
	localparam byte_t STORE_RST      = 8'hFF;

	// one reply to send: its first byte and whether settings follow
	typedef struct packed {
		byte_t first;
		logic  rd;
	} cmd_t;

	// settings store update from a completed write frame
	typedef struct packed {
		logic                     en;
		byte_t [SET_BYTES-1:0]    data;
	} store_wr_t;

	// back-end status seen by the front end
	typedef struct packed {
		logic q_full;
		logic back_idle;
	} bk_stat_t;

endpackage

// ===== rtl/ssfh_front.sv =====
// front end: collects received bytes into frames and classifies completed frames
// depends on ssfh_pkg; feeds ssfh_cmd_queue and the settings store in ssfh_back
module ssfh_front #(
	parameter int unsigned FRAME_LENGTH  = 24,
	parameter int unsigned RECEIVE_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  ssfh_pkg::byte_t     rx_byte,
	input  ssfh_pkg::byte_t     read_code,
	input  ssfh_pkg::byte_t     write_code,
	input  ssfh_pkg::byte_t     ack_code,
	input  ssfh_pkg::bk_stat_t  stat,
	output logic                cmd_push,
	output ssfh_pkg::cmd_t      cmd,
	output ssfh_pkg::store_wr_t store_wr
);

	localparam int unsigned POS_MAX =
		(FRAME_LENGTH > RECEIVE_DEPTH) ? FRAME_LENGTH : RECEIVE_DEPTH;
	localparam int unsigned POS_W = $clog2(POS_MAX + 1);

	typedef enum logic [1:0] {
		IDLE = 2'b01,
		RCV  = 2'b10
	} mode_t;

	mode_t                  mode_q;
	logic [POS_W-1:0]       pos_q;
	ssfh_pkg::byte_t        head_q;
	ssfh_pkg::byte_t        buf_q [ssfh_pkg::SET_BYTES];

	logic accept;
	logic rcv_store;
	logic completing;
	logic head_wr;
	logic head_rd;
	logic start_hit;
	logic [ssfh_pkg::SET_IDX_W-1:0] buf_idx;

	assign rcv_store  = (mode_q == RCV) && (pos_q < POS_W'(RECEIVE_DEPTH));
	assign completing = rcv_store && (pos_q == POS_W'(FRAME_LENGTH - 1));
	assign head_wr    = (head_q == write_code);
	assign head_rd    = (head_q == read_code);
	assign start_hit  = (rx_byte == read_code) || (rx_byte == write_code);
	assign buf_idx    = ssfh_pkg::SET_IDX_W'(pos_q - POS_W'(1));

	// a write commit must wait until no reply is still reading the store
	assign full   = completing && (stat.q_full || (head_wr && !stat.back_idle));
	assign accept = push && !full;

	always_comb begin
		cmd_push     = accept && completing && (head_wr || head_rd);
		cmd.rd       = !head_wr;
		cmd.first    = head_wr ? ack_code : read_code;
		store_wr.en  = accept && completing && head_wr;
		for (int i = 0; i < ssfh_pkg::SET_BYTES; i++) begin
			store_wr.data[i] = (pos_q == POS_W'(i + 1)) ? rx_byte : buf_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= IDLE;
			pos_q  <= '0;
		end else if (accept) begin
			if (rcv_store) begin
				if (completing) begin
					mode_q <= IDLE;
					pos_q  <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end else if (start_hit) begin
				// idle byte, or the byte that hit a full buffer, judged afresh
				mode_q <= RCV;
				pos_q  <= POS_W'(1);
			end else begin
				mode_q <= IDLE;
				pos_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (rcv_store && (pos_q <= POS_W'(ssfh_pkg::SET_BYTES))) begin
				buf_q[buf_idx] <= rx_byte;
			end
			if (!rcv_store && start_hit) begin
				head_q <= rx_byte;
			end
		end
	end

endmodule

// ===== rtl/ssfh_cmd_queue.sv =====
// two-entry queue of reply commands between front and back ends
// depends on ssfh_pkg for the command type
module ssfh_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  ssfh_pkg::cmd_t wdata,
	input  logic           rd,
	output ssfh_pkg::cmd_t rdata,
	output logic           q_empty,
	output logic           q_full
);

	ssfh_pkg::cmd_t ent_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	assign q_empty = (cnt_q == 2'd0);
	assign q_full  = (cnt_q == 2'd2);
	assign rdata   = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= !wp_q;
			end
			if (rd) begin
				rp_q <= !rp_q;
			end
			unique case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wp_q] <= wdata;
		end
	end

endmodule

// ===== rtl/ssfh_back.sv =====
// back end: holds the settings store and sends reply frames byte by byte
// depends on ssfh_pkg; takes commands from ssfh_cmd_queue
module ssfh_back #(
	parameter int unsigned FRAME_LENGTH = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ssfh_pkg::store_wr_t store_wr,
	input  logic                q_empty,
	input  ssfh_pkg::cmd_t      q_data,
	output logic                q_rd,
	output logic                busy,
	output logic                empty,
	input  logic                pop,
	output ssfh_pkg::byte_t     tx_byte,
	output logic                last_byte
);

	localparam int unsigned CNT_W = $clog2(FRAME_LENGTH);

	ssfh_pkg::byte_t   store_q [ssfh_pkg::SET_BYTES];
	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	ssfh_pkg::cmd_t    cur_q;

	logic [ssfh_pkg::SET_IDX_W-1:0] st_idx;
	logic                           take;

	assign st_idx = ssfh_pkg::SET_IDX_W'(cnt_q - CNT_W'(1));
	assign q_rd   = !busy_q && !q_empty;
	assign busy   = busy_q;
	assign empty  = !busy_q;
	assign take   = pop && busy_q;

	always_comb begin
		last_byte = (cnt_q == CNT_W'(FRAME_LENGTH - 1));
		priority if (cnt_q == '0) begin
			tx_byte = cur_q.first;
		end else if (cur_q.rd && (cnt_q <= CNT_W'(ssfh_pkg::SET_BYTES))) begin
			tx_byte = store_q[st_idx];
		end else begin
			tx_byte = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			for (int i = 0; i < ssfh_pkg::SET_BYTES; i++) begin
				store_q[i] <= ssfh_pkg::STORE_RST;
			end
		end else begin
			if (store_wr.en) begin
				for (int i = 0; i < ssfh_pkg::SET_BYTES; i++) begin
					store_q[i] <= store_wr.data[i];
				end
			end
			if (q_rd) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (take) begin
				if (last_byte) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_data;
		end
	end

endmodule

// ===== rtl/serial_settings_frame_handler_top.sv =====
// a completed frame's reply command passes the command queue and is loaded into the
// back end before its first reply byte shows; throughput: one item per cycle while a
// frame fills, unless full holds the closing item; one reply byte per cycle on pop,
// with empty raised between reply frames; a write frame closes only once no reply is pending
// reset: arst_n clears mode, counters and queue at once and presets the settings store to 0xff
module serial_settings_frame_handler_top #(
	parameter int unsigned FRAME_LENGTH  = 24,
	parameter int unsigned RECEIVE_DEPTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  ssfh_pkg::byte_t rx_byte,
	output logic            empty,
	input  logic            pop,
	output ssfh_pkg::byte_t tx_byte,
	output logic            last_byte,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_idx,
	input  ssfh_pkg::byte_t cfg_wdata
);

	ssfh_pkg::byte_t     read_code_q;
	ssfh_pkg::byte_t     write_code_q;
	ssfh_pkg::byte_t     ack_code_q;

	ssfh_pkg::bk_stat_t  stat;
	ssfh_pkg::store_wr_t store_wr;
	ssfh_pkg::cmd_t      cmd;
	ssfh_pkg::cmd_t      q_data;
	logic                cmd_push;
	logic                q_empty;
	logic                q_full;
	logic                q_rd;
	logic                busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_code_q  <= ssfh_pkg::READ_CODE_RST;
			write_code_q <= ssfh_pkg::WRITE_CODE_RST;
			ack_code_q   <= ssfh_pkg::ACK_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ssfh_pkg::REG_READ_CODE:  read_code_q  <= cfg_wdata;
				ssfh_pkg::REG_WRITE_CODE: write_code_q <= cfg_wdata;
				ssfh_pkg::REG_ACK_CODE:   ack_code_q   <= cfg_wdata;
				default:                  ;
			endcase
		end
	end

	assign stat.q_full    = q_full;
	assign stat.back_idle = !busy && q_empty;

	ssfh_front #(
		.FRAME_LENGTH  (FRAME_LENGTH),
		.RECEIVE_DEPTH (RECEIVE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rx_byte    (rx_byte),
		.read_code  (read_code_q),
		.write_code (write_code_q),
		.ack_code   (ack_code_q),
		.stat       (stat),
		.cmd_push   (cmd_push),
		.cmd        (cmd),
		.store_wr   (store_wr)
	);

	ssfh_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_push),
		.wdata   (cmd),
		.rd      (q_rd),
		.rdata   (q_data),
		.q_empty (q_empty),
		.q_full  (q_full)
	);

	ssfh_back #(
		.FRAME_LENGTH (FRAME_LENGTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.store_wr  (store_wr),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_rd      (q_rd),
		.busy      (busy),
		.empty     (empty),
		.pop       (pop),
		.tx_byte   (tx_byte),
		.last_byte (last_byte)
	);

	// settings must not change under a reply that is still being sent
	a_store_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		store_wr.en |-> stat.back_idle)
		else $error("settings store written while a reply is pending");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !q_full)
		else $error("reply command pushed into a full queue");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && last_byte) |=> empty)
		else $error("reply frame did not end after its last item");

endmodule
